// ----- hw/rtl/dq_pkg.sv -----
// Shared types and constants for the circular deque.
// Holds the action and status codes, the cell control struct and the sizing constants.
// No dependencies.
package dq_pkg;

  localparam int DEPTH   = 8;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W  = 4;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  typedef struct packed {
    logic take_left;
    logic take_right;
    logic load;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/circular_deque.sv -----
// Double-ended queue: a row of DEPTH cells with the front entry in cell 0.
// The result strobes in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, as every action is one cell-row update.
// Reset: rst_n (synchronous, active low) empties the queue and drops any pending result;
// cell contents are not cleared. The receiver cannot stall the result.
module circular_deque (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  dq_pkg::action_t                   in_action,
  input  logic signed [dq_pkg::DATA_W-1:0]  in_push_value,
  output logic                              out_strobe,
  output dq_pkg::status_t                   out_status,
  output logic signed [dq_pkg::DATA_W-1:0]  out_popped_value,
  output logic [dq_pkg::FILL_W-1:0]         out_fill_count
);
  import dq_pkg::*;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [CNT_W-1:0]         count_dec;
  logic                     full;
  logic                     empty;
  logic                     accept;
  cell_ctl_t                ctl [DEPTH];
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic signed [DATA_W-1:0] popped_nxt;
  status_t                  status_nxt;

  logic                     out_strobe_r;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_popped_r;
  logic [FILL_W-1:0]        out_fill_r;

  assign busy      = 1'b0;
  assign accept    = start & ~busy;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign count_dec = count_r - CNT_W'(1);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    popped_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      ctl[i] = '0;
    end
    case (in_action)
      ACT_PUSH_FRONT: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            ctl[i].take_left = accept;
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_PUSH_BACK: begin
        if (full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            ctl[i].load = accept && (count_r == CNT_W'(i));
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ACT_POP_FRONT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            ctl[i].take_right = accept;
          end
          popped_nxt = cell_q[0];
          count_nxt  = count_dec;
        end
      end
      ACT_POP_BACK: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          popped_nxt = cell_q[count_dec[IDX_W-1:0]];
          count_nxt  = count_dec;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = in_push_value;
    end else begin : g_inner_l
      assign left_d = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_d = cell_q[g];
    end else begin : g_inner_r
      assign right_d = cell_q[g+1];
    end
    dq_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .left_d  (left_d),
      .right_d (right_d),
      .push_d  (in_push_value),
      .q       (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_popped_r <= popped_nxt;
      out_fill_r   <= count_nxt[FILL_W-1:0];
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_fill_count   = out_fill_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count beyond depth");

  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_strobe_r)
    else $error("accepted transaction gave no result");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && (out_status_r != ST_DONE) && $past(rst_n) |-> count_r == $past(count_r))
    else $error("refused transaction changed the fill count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && (out_status_r == ST_EMPTY) |-> out_popped_r == '0 && out_fill_r == '0)
    else $error("refused pop returned data");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && (out_status_r == ST_OVERFLOW) |-> full)
    else $error("overflow reported while not full");
`endif

endmodule

// ----- hw/rtl/dq_cell.sv -----
// One storage cell of the deque chain.
// Takes its left or right neighbor's entry, or the pushed value; holds otherwise.
// Depends on dq_pkg.
module dq_cell (
  input  logic                              clk,
  input  dq_pkg::cell_ctl_t                 ctl,
  input  logic signed [dq_pkg::DATA_W-1:0]  left_d,
  input  logic signed [dq_pkg::DATA_W-1:0]  right_d,
  input  logic signed [dq_pkg::DATA_W-1:0]  push_d,
  output logic signed [dq_pkg::DATA_W-1:0]  q
);
  import dq_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.take_left) begin
      data_nxt = left_d;
    end else if (ctl.take_right) begin
      data_nxt = right_d;
    end else if (ctl.load) begin
      data_nxt = push_d;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule
